FILE: hdl/bir_pkg.sv
// Shared types and constants for the bilinear image rotator.
package bir_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_SRC_W = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SRC_H = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OUT_W = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OUT_H = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PIV_X = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PIV_Y = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SIN = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_COS = 3'd7;
	localparam int unsigned CfgDataW = 18;
	localparam int unsigned SubBits = 4;
	localparam int MaxWidth = 256;
	localparam int MaxHeight = 256;

	typedef struct packed {
		logic [8:0] src_w;
		logic [8:0] src_h;
		logic [8:0] out_w;
		logic [8:0] out_h;
		logic signed [9:0] piv_x;
		logic signed [9:0] piv_y;
		logic signed [17:0] sin_v;
		logic signed [17:0] cos_v;
	} cfg_t;
endpackage

FILE: hdl/bir_map.sv
// Rotation front end: maps an output pixel to a source position with sub-pixel fraction.
module bir_map #(
	parameter int FRAC_BITS = 12,
	parameter int XW = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  bir_pkg::cfg_t cfg,
	input  logic in_vld,
	input  logic [7:0] px,
	input  logic [7:0] py,
	output logic out_vld,
	output logic signed [XW+1:0] sx,
	output logic signed [XW+1:0] sy,
	output logic [3:0] fx,
	output logic [3:0] fy
);
	import bir_pkg::*;
	localparam int PW = 28;
	logic v_s1, v_s2;
	logic signed [9:0] dx_s1, dy_s1;
	logic signed [PW-1:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [PW-1:0] nu, nv, u, v;
	logic signed [PW-1:0] bu, bv;
	logic signed [PW-1:0] ux, vy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			out_vld <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({2'b00, cfg.out_w[8:1]}) - $signed({2'b00, px});
		dy_s1 <= $signed({2'b00, cfg.out_h[8:1]}) - $signed({2'b00, py});
		pxc_s2 <= PW'(dx_s1 * cfg.cos_v);
		pys_s2 <= PW'(dy_s1 * cfg.sin_v);
		pyc_s2 <= PW'(dy_s1 * cfg.cos_v);
		pxs_s2 <= PW'(dx_s1 * cfg.sin_v);
	end

	always_comb begin
		nu = -pxc_s2 - pys_s2;
		nv = pxs_s2 - pyc_s2;
		bu = nu + (nu[PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
		bv = nv + (nv[PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
		u = bu >>> FRAC_BITS;
		v = bv >>> FRAC_BITS;
		ux = u >>> SubBits;
		vy = v >>> SubBits;
	end

	always_ff @(posedge clk) begin
		sx <= (XW+2)'(ux + PW'(cfg.piv_x));
		sy <= (XW+2)'(vy + PW'(cfg.piv_y));
		fx <= u[3:0];
		fy <= v[3:0];
	end
endmodule

FILE: hdl/bir_store.sv
// Source image store in four parity banks with a registered bounds check.
module bir_store #(
	parameter int XW = 9,
	parameter int AW = 8,
	parameter int CH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  bir_pkg::cfg_t cfg,
	input  logic wr_en,
	input  logic [7:0] wx,
	input  logic [7:0] wy,
	input  logic [8*CH-1:0] wdata,
	input  logic rd_vld,
	input  logic signed [XW+1:0] sx,
	input  logic signed [XW+1:0] sy,
	input  logic [3:0] fx_in,
	input  logic [3:0] fy_in,
	output logic out_vld,
	output logic [4*8*CH-1:0] pix,
	output logic [3:0] fx,
	output logic [3:0] fy
);
	import bir_pkg::*;
	localparam int BA = 2*AW - 2;
	logic [8*CH-1:0] mem0 [0:(1<<BA)-1];
	logic [8*CH-1:0] mem1 [0:(1<<BA)-1];
	logic [8*CH-1:0] mem2 [0:(1<<BA)-1];
	logic [8*CH-1:0] mem3 [0:(1<<BA)-1];
	logic signed [XW+1:0] x1, y1, xe, xo, ye, yo, wl, hl;
	logic [BA-1:0] a0, a1, a2, a3, wa;
	logic [8*CH-1:0] r0, r1, r2, r3;
	logic [3:0] in_s;
	logic sw_x, sw_y;
	logic [1:0] wb;
	logic ix0, ix1, iy0, iy1;

	always_comb begin
		wl = (cfg.src_w > 9'(MaxWidth)) ? (XW+2)'(MaxWidth) : (XW+2)'(cfg.src_w);
		hl = (cfg.src_h > 9'(MaxHeight)) ? (XW+2)'(MaxHeight) : (XW+2)'(cfg.src_h);
		x1 = sx + (XW+2)'(1);
		y1 = sy + (XW+2)'(1);
		ix0 = !sx[XW+1] && sx < wl;
		ix1 = !x1[XW+1] && x1 < wl;
		iy0 = !sy[XW+1] && sy < hl;
		iy1 = !y1[XW+1] && y1 < hl;
		xe = sx[0] ? x1 : sx;
		xo = sx[0] ? sx : x1;
		ye = sy[0] ? y1 : sy;
		yo = sy[0] ? sy : y1;
		a0 = {ye[AW-1:1], xe[AW-1:1]};
		a1 = {ye[AW-1:1], xo[AW-1:1]};
		a2 = {yo[AW-1:1], xe[AW-1:1]};
		a3 = {yo[AW-1:1], xo[AW-1:1]};
		wa = {wy[AW-1:1], wx[AW-1:1]};
		wb = {wy[0], wx[0]};
	end

	always_ff @(posedge clk) begin
		if (wr_en && wb == 2'd0) mem0[wa] <= wdata;
		if (wr_en && wb == 2'd1) mem1[wa] <= wdata;
		if (wr_en && wb == 2'd2) mem2[wa] <= wdata;
		if (wr_en && wb == 2'd3) mem3[wa] <= wdata;
		r0 <= mem0[a0];
		r1 <= mem1[a1];
		r2 <= mem2[a2];
		r3 <= mem3[a3];
		in_s <= {ix1 && iy1, ix0 && iy1, ix1 && iy0, ix0 && iy0};
		sw_x <= sx[0];
		sw_y <= sy[0];
		fx <= fx_in;
		fy <= fy_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= rd_vld;
		end
	end

	logic [8*CH-1:0] e0, e1, o0, o1, p00, p10, p01, p11;
	always_comb begin
		e0 = sw_x ? r1 : r0;
		o0 = sw_x ? r0 : r1;
		e1 = sw_x ? r3 : r2;
		o1 = sw_x ? r2 : r3;
		p00 = sw_y ? e1 : e0;
		p10 = sw_y ? o1 : o0;
		p01 = sw_y ? e0 : e1;
		p11 = sw_y ? o0 : o1;
		pix = {in_s[3] ? p11 : '0, in_s[2] ? p01 : '0,
			in_s[1] ? p10 : '0, in_s[0] ? p00 : '0};
	end
endmodule

FILE: hdl/bir_blend.sv
// Bilinear blend of four neighbors with rounding, two register stages.
module bir_blend #(
	parameter int CH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [4*8*CH-1:0] pix,
	input  logic [3:0] fx,
	input  logic [3:0] fy,
	output logic out_vld,
	output logic [8*CH-1:0] res
);
	logic [8:0] w00, w10, w01, w11;
	logic [8:0] w_s1 [4];
	logic [4*8*CH-1:0] pix_s1;
	logic v_s1;
	logic [17:0] acc [CH];

	always_comb begin
		w00 = 9'((5'd16 - {1'b0, fx}) * (5'd16 - {1'b0, fy}));
		w10 = 9'({1'b0, fx} * (5'd16 - {1'b0, fy}));
		w01 = 9'((5'd16 - {1'b0, fx}) * {1'b0, fy});
		w11 = 9'(fx * fy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			out_vld <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1[0] <= w00;
		w_s1[1] <= w10;
		w_s1[2] <= w01;
		w_s1[3] <= w11;
		pix_s1 <= pix;
	end

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			acc[c] = 18'(w_s1[0] * pix_s1[8*c +: 8])
				+ 18'(w_s1[1] * pix_s1[8*CH + 8*c +: 8])
				+ 18'(w_s1[2] * pix_s1[16*CH + 8*c +: 8])
				+ 18'(w_s1[3] * pix_s1[24*CH + 8*c +: 8]) + 18'd128;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CH; c++) begin
			res[8*c +: 8] <= acc[c][15:8];
		end
	end
endmodule

FILE: hdl/bilinear_image_rotator.sv
// Top level of the bilinear image rotator.
// A beat is taken on each clock edge where start is high (busy is always low).
// cmd 0 loads one RGBA pixel into the source store; cmd 1 renders one
// output pixel by rotating its offset from the output center about the pivot
// and blending four source neighbors bilinearly.
// One beat enters every cycle; throughput is one pixel per cycle because the
// store is split into four banks by x and y parity, one neighbor per bank.
// A render beat yields its result on out_red..out_alpha with done high
// after the rotation, store read and blending stages. Load beats yield no
// result; a load passes through the wr_s1..wr_s3 registers before it reaches
// the store, in step with the reads of renders.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while no beat is in flight.
// Reset clears the valid bits and restores register defaults; the store
// contents are undefined until loaded. The receiver cannot stall.
module bilinear_image_rotator #(
	parameter int CHANNELS = 4,
	parameter int FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cmd,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	input  logic [7:0] in_alpha,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bir_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bir_pkg::CfgDataW-1:0] cfg_data,
	output logic done,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha
);
	import bir_pkg::*;
	localparam int XW = 9;
	localparam int AW = 8;
	cfg_t cfg_q;
	logic mv, sv, bv, wr;
	logic wr_s1, wr_s2, wr_s3;
	logic [7:0] wx_s1, wx_s2, wx_s3, wy_s1, wy_s2, wy_s3;
	logic [8*CHANNELS-1:0] wd_s1, wd_s2, wd_s3;
	logic signed [XW+1:0] sx, sy;
	logic [3:0] fx, fy, fx2, fy2;
	logic [4*8*CHANNELS-1:0] pix;
	logic [8*CHANNELS-1:0] res, wdata;
	logic [31:0] full;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign full = {in_alpha, in_blue, in_green, in_red};
	assign wdata = full[8*CHANNELS-1:0];
	assign wr = start && !cmd && (32'(pos_x) < MaxWidth) && (32'(pos_y) < MaxHeight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
			wr_s3 <= 1'b0;
		end else begin
			wr_s1 <= wr;
			wr_s2 <= wr_s1;
			wr_s3 <= wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= pos_x;
		wy_s1 <= pos_y;
		wd_s1 <= wdata;
		wx_s2 <= wx_s1;
		wy_s2 <= wy_s1;
		wd_s2 <= wd_s1;
		wx_s3 <= wx_s2;
		wy_s3 <= wy_s2;
		wd_s3 <= wd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{9'd256, 9'd256, 9'd256, 9'd256, 10'sd128, 10'sd128, 18'sd0,
				18'sd65536};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SRC_W: cfg_q.src_w <= cfg_data[8:0];
				REG_SRC_H: cfg_q.src_h <= cfg_data[8:0];
				REG_OUT_W: cfg_q.out_w <= cfg_data[8:0];
				REG_OUT_H: cfg_q.out_h <= cfg_data[8:0];
				REG_PIV_X: cfg_q.piv_x <= cfg_data[9:0];
				REG_PIV_Y: cfg_q.piv_y <= cfg_data[9:0];
				REG_SIN: cfg_q.sin_v <= cfg_data;
				REG_COS: cfg_q.cos_v <= cfg_data;
				default: ;
			endcase
		end
	end

	bir_map #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_map (
		.clk, .arst_n, .cfg(cfg_q), .in_vld(start && cmd), .px(pos_x), .py(pos_y),
		.out_vld(mv), .sx, .sy, .fx, .fy
	);

	bir_store #(.XW(XW), .AW(AW), .CH(CHANNELS)) u_store (
		.clk, .arst_n, .cfg(cfg_q), .wr_en(wr_s3), .wx(wx_s3), .wy(wy_s3), .wdata(wd_s3),
		.rd_vld(mv), .sx, .sy, .fx_in(fx), .fy_in(fy), .out_vld(sv), .pix,
		.fx(fx2), .fy(fy2)
	);

	bir_blend #(.CH(CHANNELS)) u_blend (
		.clk, .arst_n, .in_vld(sv), .pix, .fx(fx2), .fy(fy2), .out_vld(bv), .res
	);

	logic [31:0] res_full;
	assign res_full = 32'(res);
	assign done = bv;
	assign out_red = res_full[7:0];
	assign out_green = res_full[15:8];
	assign out_blue = res_full[23:16];
	assign out_alpha = res_full[31:24];
endmodule

FILE: verif/bir_checker.sv
// Checker for the bilinear image rotator: watches the beats, predicts renders, compares results.
module bir_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic cmd,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	input  logic [7:0] in_alpha,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [bir_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bir_pkg::CfgDataW-1:0] cfg_data,
	input  logic done,
	input  logic [7:0] out_red,
	input  logic [7:0] out_green,
	input  logic [7:0] out_blue,
	input  logic [7:0] out_alpha,
	output int errors,
	output int pending,
	output int renders
);
	timeunit 1ns;
	timeprecision 1ps;
	import bir_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	cfg_t regs;
	logic [31:0] pixels [0:65535];
	rgba_t pixel_queue [$];

	function automatic logic [7:0] channel_at(longint x, longint y, int ch);
		logic [31:0] p;
		if (x < 0 || y < 0 || x >= longint'(regs.src_w) || y >= longint'(regs.src_h)
			|| x >= 256 || y >= 256)
			return 8'd0;
		p = pixels[y * 256 + x];
		return p[8 * ch +: 8];
	endfunction

	function automatic rgba_t blend_pixel(logic [7:0] ox, logic [7:0] oy);
		longint dx, dy, u, v, sx, sy, acc;
		longint fx, fy;
		logic [7:0] c [4];
		rgba_t res;
		dx = longint'(regs.out_w >> 1) - longint'(ox);
		dy = longint'(regs.out_h >> 1) - longint'(oy);
		u = (-dx * longint'(regs.cos_v) - dy * longint'(regs.sin_v)) / 4096;
		v = (-dy * longint'(regs.cos_v) + dx * longint'(regs.sin_v)) / 4096;
		fx = u & 15;
		fy = v & 15;
		sx = longint'(regs.piv_x) + (u - fx) / 16;
		sy = longint'(regs.piv_y) + (v - fy) / 16;
		for (int ch = 0; ch < 4; ch++) begin
			acc = (16 - fx) * (16 - fy) * channel_at(sx, sy, ch)
				+ fx * (16 - fy) * channel_at(sx + 1, sy, ch)
				+ (16 - fx) * fy * channel_at(sx, sy + 1, ch)
				+ fx * fy * channel_at(sx + 1, sy + 1, ch) + 128;
			c[ch] = 8'((acc / 256) & 255);
		end
		res.r = c[0];
		res.g = c[1];
		res.b = c[2];
		res.a = c[3];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		if (!arst_n) begin
			regs.src_w <= 9'd256;
			regs.src_h <= 9'd256;
			regs.out_w <= 9'd256;
			regs.out_h <= 9'd256;
			regs.piv_x <= 10'sd128;
			regs.piv_y <= 10'sd128;
			regs.sin_v <= 18'sd0;
			regs.cos_v <= 18'sd65536;
			errors <= 0;
			renders <= 0;
			pixel_queue.delete();
		end else begin
			if (done) begin
				if (pixel_queue.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = pixel_queue.pop_front();
					if (out_red !== want.r) report_mismatch("red", out_red, want.r);
					if (out_green !== want.g) report_mismatch("green", out_green, want.g);
					if (out_blue !== want.b) report_mismatch("blue", out_blue, want.b);
					if (out_alpha !== want.a) report_mismatch("alpha", out_alpha, want.a);
				end
			end
			if (start && !busy) begin
				if (cmd) begin
					pixel_queue.push_back(blend_pixel(pos_x, pos_y));
					renders <= renders + 1;
				end else begin
					pixels[{pos_y, pos_x}] = {in_alpha, in_blue, in_green, in_red};
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SRC_W: regs.src_w <= cfg_data[8:0];
					REG_SRC_H: regs.src_h <= cfg_data[8:0];
					REG_OUT_W: regs.out_w <= cfg_data[8:0];
					REG_OUT_H: regs.out_h <= cfg_data[8:0];
					REG_PIV_X: regs.piv_x <= cfg_data[9:0];
					REG_PIV_Y: regs.piv_y <= cfg_data[9:0];
					REG_SIN: regs.sin_v <= cfg_data;
					REG_COS: regs.cos_v <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign pending = pixel_queue.size();
endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for the bilinear image rotator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bir_pkg::*;

	logic clk, arst_n, start, busy, cmd, cfg_valid, cfg_ready, done;
	logic [7:0] pos_x, pos_y, in_red, in_green, in_blue, in_alpha;
	logic [7:0] out_red, out_green, out_blue, out_alpha;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int errors, pending, renders, beats;
	longint cycles;
	int gap_pct;

	bilinear_image_rotator dut (.*);
	bir_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("timeout after %0d cycles", cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Source image kept fully loaded over 16x16 so renders never hit an unwritten entry.
	task automatic send(logic c, logic [7:0] x, logic [7:0] y, logic [31:0] rgba);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		{in_alpha, in_blue, in_green, in_red} <= rgba;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		beats++;
	endtask

	task automatic idle_then_write(logic [CfgIdxW-1:0] idx, int value);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(int sw, int sh, int ow, int oh, int px, int py, int s, int c);
		idle_then_write(REG_SRC_W, sw);
		idle_then_write(REG_SRC_H, sh);
		idle_then_write(REG_OUT_W, ow);
		idle_then_write(REG_OUT_H, oh);
		idle_then_write(REG_PIV_X, px);
		idle_then_write(REG_PIV_Y, py);
		idle_then_write(REG_SIN, s);
		idle_then_write(REG_COS, c);
	endtask

	task automatic render_burst(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send(1'b0, 8'($urandom_range(15)), 8'($urandom_range(15)), $urandom());
			else
				send(1'b1, 8'($urandom()), 8'($urandom()), $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = 1'b0;
		pos_x = '0;
		pos_y = '0;
		{in_alpha, in_blue, in_green, in_red} = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_W;
		cfg_data = '0;
		gap_pct = 0;
		beats = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Small source so random renders only ever touch loaded entries.
		setup(16, 16, 64, 64, 8, 8, 0, 65536);
		for (int y = 0; y < 16; y++)
			for (int x = 0; x < 16; x++)
				send(1'b0, 8'(x), 8'(y), $urandom());
		send(1'b0, 8'd0, 8'd0, 32'hffffffff);
		send(1'b0, 8'd15, 8'd15, 32'h00000000);
		send(1'b1, 8'd0, 8'd0, 0);
		send(1'b1, 8'd255, 8'd255, 0);
		send(1'b1, 8'd32, 8'd32, 0);
		send(1'b1, 8'd17, 8'd45, 0);
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: gap_pct = 0;
				1: gap_pct = 57;
				2: gap_pct = 0;
				default: gap_pct = 34;
			endcase
			case (ph)
				0: setup(16, 16, 256, 256, 8, 8, 65536, 0);
				1: setup(0, 16, 1, 1, -256, 511, -65536, -65536);
				2: setup(16, 16, 0, 511, 511, -256, 131071, 131072);
				3: setup(1, 1, 64, 64, 0, 0, 4000, 65000);
				default: setup($urandom_range(16), $urandom_range(16), $urandom_range(511),
					$urandom_range(511), $urandom_range(31) - 8, $urandom_range(31) - 8,
					$urandom_range(131071) - 65536, $urandom_range(131071) - 65536);
			endcase
			render_burst(130);
		end
		setup(511, 300, 256, 256, 8, 8, 0, 65536);
		gap_pct = 0;
		send(1'b1, 8'd128, 8'd128, 0);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		$display("Ran %0d beats with %0d renders over ten register settings,", beats, renders);
		$display("including zero, oversized and random sizes, pivots and angles.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: sim.f
hdl/bir_pkg.sv
hdl/bir_map.sv
hdl/bir_store.sv
hdl/bir_blend.sv
hdl/bilinear_image_rotator.sv
verif/bir_checker.sv
verif/testbench.sv
